>>> hdl/qcir_char_tokenizer_assert.svh
// Assertion macros shared by the tokenizer modules.
`ifndef QCIR_CHAR_TOKENIZER_ASSERT_SVH
`define QCIR_CHAR_TOKENIZER_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define QCT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qct assertion failed");

// Next-cycle implication.
`define QCT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qct assertion failed");

`endif

>>> hdl/qct_pkg.sv
package qct_pkg;

  localparam int VALUE_BITS = 31;
  localparam int LINE_BITS = 24;
  localparam int CHAR_W = 8;
  localparam int KIND_W = 5;
  localparam int TVALUE_W = 32;
  localparam int TOKEN_W = KIND_W + TVALUE_W + LINE_BITS;
  localparam int OUT_DATA_W = ((TOKEN_W + 7) / 8) * 8;
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

  localparam logic [KIND_W-1:0] K_FORALL  = 5'd0;
  localparam logic [KIND_W-1:0] K_EXISTS  = 5'd1;
  localparam logic [KIND_W-1:0] K_FREE    = 5'd2;
  localparam logic [KIND_W-1:0] K_OUTPUT  = 5'd3;
  localparam logic [KIND_W-1:0] K_VAR     = 5'd4;
  localparam logic [KIND_W-1:0] K_LIT     = 5'd5;
  localparam logic [KIND_W-1:0] K_EQ      = 5'd6;
  localparam logic [KIND_W-1:0] K_COMMA   = 5'd7;
  localparam logic [KIND_W-1:0] K_SEMI    = 5'd8;
  localparam logic [KIND_W-1:0] K_LPAREN  = 5'd9;
  localparam logic [KIND_W-1:0] K_RPAREN  = 5'd10;
  localparam logic [KIND_W-1:0] K_COMMENT = 5'd11;
  localparam logic [KIND_W-1:0] K_HEADER  = 5'd12;
  localparam logic [KIND_W-1:0] K_SYMTAB  = 5'd13;
  localparam logic [KIND_W-1:0] K_EOL     = 5'd14;
  localparam logic [KIND_W-1:0] K_EOF     = 5'd15;
  localparam logic [KIND_W-1:0] K_AND     = 5'd16;
  localparam logic [KIND_W-1:0] K_OR      = 5'd17;
  localparam logic [KIND_W-1:0] K_ERROR   = 5'd18;

  localparam logic [TVALUE_W-1:0] ERR_UNKNOWN  = 32'd0;
  localparam logic [TVALUE_W-1:0] ERR_MINUS    = 32'd1;
  localparam logic [TVALUE_W-1:0] ERR_OVERFLOW = 32'd2;

  localparam logic [CHAR_W-1:0] CH_NL     = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_HASH   = 8'h23;
  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
  localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
  localparam logic [CHAR_W-1:0] CH_EQ     = 8'h3D;
  localparam logic [CHAR_W-1:0] CH_UC_A   = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UC_Q   = 8'h51;
  localparam logic [CHAR_W-1:0] CH_UC_Z   = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_A      = 8'h61;
  localparam logic [CHAR_W-1:0] CH_E      = 8'h65;
  localparam logic [CHAR_W-1:0] CH_F      = 8'h66;
  localparam logic [CHAR_W-1:0] CH_O      = 8'h6F;
  localparam logic [CHAR_W-1:0] CH_R      = 8'h72;
  localparam logic [CHAR_W-1:0] CH_S      = 8'h73;

  // keyword candidates
  localparam logic [2:0] KW_FORALL = 3'd0;
  localparam logic [2:0] KW_EXISTS = 3'd1;
  localparam logic [2:0] KW_OUTPUT = 3'd2;
  localparam logic [2:0] KW_FREE   = 3'd3;
  localparam logic [2:0] KW_AND    = 3'd4;
  localparam logic [2:0] KW_OR     = 3'd5;
  localparam logic [2:0] KW_LAST   = KW_OR;

  // marker candidates
  localparam logic [1:0] MK_HEADER = 2'd0;
  localparam logic [1:0] MK_SYMTAB = 2'd1;
  localparam logic [1:0] MK_NONE   = 2'd2;

  typedef enum logic [2:0] {
    M_IDLE,
    M_NUMBER,
    M_MINUS,
    M_KEYWORD,
    M_HASH,
    M_COMMENT,
    M_ERROR
  } mode_t;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [TVALUE_W-1:0]  value;
    logic [LINE_BITS-1:0] line;
    logic                 last;
  } tok_t;

  typedef struct packed {
    logic [1:0] cnt;
    tok_t       t0;
    tok_t       t1;
  } tok_pair_t;

  function automatic logic [CHAR_W-1:0] to_lower(input logic [CHAR_W-1:0] c);
    return (c >= CH_UC_A && c <= CH_UC_Z) ? (c | 8'h20) : c;
  endfunction

  function automatic logic [47:0] kw_text(input logic [2:0] k);
    logic [47:0] s;
    case (k)
      KW_FORALL: s = "forall";
      KW_EXISTS: s = "exists";
      KW_OUTPUT: s = "output";
      KW_FREE:   s = {"free", 16'h0};
      KW_AND:    s = {"and", 24'h0};
      KW_OR:     s = {"or", 32'h0};
      default:   s = '0;
    endcase
    return s;
  endfunction

  function automatic logic [CHAR_W-1:0] kw_char(input logic [2:0] k, input logic [3:0] i);
    logic [47:0] s;
    logic [CHAR_W-1:0] c;
    s = kw_text(k);
    case (i)
      4'd0:    c = s[47:40];
      4'd1:    c = s[39:32];
      4'd2:    c = s[31:24];
      4'd3:    c = s[23:16];
      4'd4:    c = s[15:8];
      4'd5:    c = s[7:0];
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic logic [3:0] kw_len(input logic [2:0] k);
    logic [3:0] n;
    case (k)
      KW_FORALL, KW_EXISTS, KW_OUTPUT: n = 4'd6;
      KW_FREE: n = 4'd4;
      KW_AND:  n = 4'd3;
      KW_OR:   n = 4'd2;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

  function automatic logic [KIND_W-1:0] kw_kind(input logic [2:0] k);
    logic [KIND_W-1:0] r;
    case (k)
      KW_FORALL: r = K_FORALL;
      KW_EXISTS: r = K_EXISTS;
      KW_OUTPUT: r = K_OUTPUT;
      KW_FREE:   r = K_FREE;
      KW_AND:    r = K_AND;
      default:   r = K_OR;
    endcase
    return r;
  endfunction

  function automatic logic [CHAR_W-1:0] mark_char(input logic [1:0] m, input logic [3:0] i);
    logic [87:0] s;
    logic [CHAR_W-1:0] c;
    case (m)
      MK_HEADER: s = {"QCIR-G14", 24'h0};
      MK_SYMTAB: s = "symboltable";
      default:   s = '0;
    endcase
    case (i)
      4'd0:    c = s[87:80];
      4'd1:    c = s[79:72];
      4'd2:    c = s[71:64];
      4'd3:    c = s[63:56];
      4'd4:    c = s[55:48];
      4'd5:    c = s[47:40];
      4'd6:    c = s[39:32];
      4'd7:    c = s[31:24];
      4'd8:    c = s[23:16];
      4'd9:    c = s[15:8];
      4'd10:   c = s[7:0];
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic logic [3:0] mark_len(input logic [1:0] m);
    logic [3:0] n;
    case (m)
      MK_HEADER: n = 4'd8;
      MK_SYMTAB: n = 4'd11;
      default:   n = 4'd0;
    endcase
    return n;
  endfunction

  function automatic tok_pair_t push(input tok_pair_t p, input logic [KIND_W-1:0] kind,
                                     input logic [TVALUE_W-1:0] value,
                                     input logic [LINE_BITS-1:0] line);
    tok_pair_t r;
    r = p;
    case (p.cnt)
      2'd0: begin
        r.t0 = '{kind: kind, value: value, line: line, last: 1'b0};
        r.cnt = 2'd1;
      end
      2'd1: begin
        r.t1 = '{kind: kind, value: value, line: line, last: 1'b0};
        r.cnt = 2'd2;
      end
      default: r = p;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/qct_lexer.sv
`include "qcir_char_tokenizer_assert.svh"

module qct_lexer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  logic [qct_pkg::CHAR_W-1:0] ch,
  input  logic                       eoi,
  output qct_pkg::tok_pair_t         toks
);
  import qct_pkg::*;

  localparam int PROD_W = VALUE_BITS + 4;
  localparam logic [PROD_W-1:0] ACC_MAX = {4'b0, {VALUE_BITS{1'b1}}};

  mode_t                 mode, mode_next;
  logic [VALUE_BITS-1:0] acc, acc_next;
  logic                  neg, neg_next;
  logic [2:0]            cand, cand_next;
  logic [3:0]            idx, idx_next;
  logic                  symtab, symtab_next;
  logic [LINE_BITS-1:0]  line_count, line_next;

  logic [CHAR_W-1:0]     lc;
  logic                  isd;
  logic [3:0]            dval;
  logic [PROD_W-1:0]     prod;
  logic                  ovf;
  logic [TVALUE_W-1:0]   num_value;
  logic [KIND_W-1:0]     num_kind;
  logic [2:0]            kk;
  logic [1:0]            mm;
  logic                  nl;
  logic                  do_start;
  tok_pair_t             tp;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      acc <= '0;
      neg <= 1'b0;
      cand <= '0;
      idx <= '0;
      symtab <= 1'b0;
      line_count <= LINE_BITS'(1);
    end else if (step) begin
      mode <= mode_next;
      acc <= acc_next;
      neg <= neg_next;
      cand <= cand_next;
      idx <= idx_next;
      symtab <= symtab_next;
      line_count <= line_next;
    end
  end

  always_comb begin
    lc = to_lower(ch);
    isd = (ch >= CH_ZERO) && (ch <= CH_NINE);
    dval = 4'(ch - CH_ZERO);
    prod = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + PROD_W'(dval);
    ovf = prod > ACC_MAX;
    num_value = neg ? (TVALUE_W'(0) - TVALUE_W'(acc)) : TVALUE_W'(acc);
    num_kind = neg ? K_LIT : K_VAR;

    mode_next = mode;
    acc_next = acc;
    neg_next = neg;
    cand_next = cand;
    idx_next = idx;
    symtab_next = symtab;
    line_next = line_count;
    kk = cand;
    mm = MK_NONE;
    nl = 1'b0;
    do_start = 1'b0;
    tp = '0;

    if (eoi) begin
      case (mode)
        M_NUMBER:  tp = push(tp, num_kind, num_value, line_count);
        M_MINUS:   tp = push(tp, K_ERROR, ERR_MINUS, line_count);
        M_KEYWORD: tp = push(tp, K_ERROR, ERR_UNKNOWN, line_count);
        default: ;
      endcase
      tp = push(tp, K_EOF, '0, line_count);
      mode_next = M_IDLE;
      acc_next = '0;
      neg_next = 1'b0;
      cand_next = '0;
      idx_next = '0;
      symtab_next = 1'b0;
      line_next = LINE_BITS'(1);
    end else begin
      case (mode)
        M_NUMBER, M_MINUS: begin
          if (isd) begin
            if (ovf) begin
              tp = push(tp, K_ERROR, ERR_OVERFLOW, line_count);
              mode_next = M_ERROR;
            end else begin
              acc_next = prod[VALUE_BITS-1:0];
              mode_next = M_NUMBER;
            end
          end else if (mode == M_NUMBER) begin
            tp = push(tp, num_kind, num_value, line_count);
            mode_next = M_IDLE;
            do_start = 1'b1;
          end else if (ch != CH_SPACE) begin
            tp = push(tp, K_ERROR, ERR_MINUS, line_count);
            mode_next = M_ERROR;
          end
        end
        M_KEYWORD: begin
          if (cand > KW_LAST || idx >= kw_len(cand)) begin
            tp = push(tp, K_ERROR, ERR_UNKNOWN, line_count);
            mode_next = M_ERROR;
          end else begin
            // "fr" and "or" split off from forall and output
            if (idx == 4'd1 && lc == CH_R) begin
              if (cand == KW_FORALL) kk = KW_FREE;
              else if (cand == KW_OUTPUT) kk = KW_OR;
              cand_next = kk;
            end
            if (lc != kw_char(kk, idx)) begin
              tp = push(tp, K_ERROR, ERR_UNKNOWN, line_count);
              mode_next = M_ERROR;
            end else begin
              idx_next = idx + 4'd1;
              if (idx + 4'd1 == kw_len(kk)) begin
                tp = push(tp, kw_kind(kk), '0, line_count);
                mode_next = M_IDLE;
              end
            end
          end
        end
        M_HASH: begin
          if (idx == 4'd0) begin
            if (ch == CH_UC_Q) mm = MK_HEADER;
            else if (ch == CH_S) mm = MK_SYMTAB;
            else mm = MK_NONE;
            cand_next = 3'(mm);
          end else begin
            mm = 2'(cand);
          end
          if (cand_next > 3'(MK_SYMTAB) || idx >= mark_len(mm) || ch != mark_char(mm, idx)) begin
            if (ch == CH_NL) begin
              mode_next = M_IDLE;
              nl = 1'b1;
            end else begin
              mode_next = M_COMMENT;
            end
          end else begin
            idx_next = idx + 4'd1;
            if (idx + 4'd1 == mark_len(mm)) begin
              mode_next = M_IDLE;
              if (mm == MK_HEADER) begin
                tp = push(tp, K_HEADER, '0, line_count);
              end else begin
                tp = push(tp, K_SYMTAB, '0, line_count);
                symtab_next = 1'b1;
              end
            end
          end
        end
        M_COMMENT: begin
          if (ch == CH_NL) begin
            mode_next = M_IDLE;
            nl = 1'b1;
          end
        end
        M_ERROR: ;
        default: do_start = 1'b1;
      endcase

      if (do_start) begin
        mode_next = M_IDLE;
        case (ch)
          CH_SPACE: ;
          CH_NL:     nl = 1'b1;
          CH_EQ:     tp = push(tp, K_EQ, '0, line_count);
          CH_COMMA:  tp = push(tp, K_COMMA, '0, line_count);
          CH_SEMI:   tp = push(tp, K_SEMI, '0, line_count);
          CH_LPAREN: tp = push(tp, K_LPAREN, '0, line_count);
          CH_RPAREN: tp = push(tp, K_RPAREN, '0, line_count);
          CH_MINUS: begin
            mode_next = M_MINUS;
            neg_next = 1'b1;
            acc_next = '0;
          end
          CH_HASH: begin
            if (symtab) begin
              tp = push(tp, K_COMMENT, '0, line_count);
            end else begin
              mode_next = M_HASH;
              idx_next = '0;
            end
          end
          default: begin
            if (isd) begin
              mode_next = M_NUMBER;
              neg_next = 1'b0;
              acc_next = VALUE_BITS'(dval);
            end else if (lc == CH_F || lc == CH_E || lc == CH_O || lc == CH_A) begin
              if (lc == CH_F) cand_next = KW_FORALL;
              else if (lc == CH_E) cand_next = KW_EXISTS;
              else if (lc == CH_O) cand_next = KW_OUTPUT;
              else cand_next = KW_AND;
              mode_next = M_KEYWORD;
              idx_next = 4'd1;
            end else begin
              tp = push(tp, K_ERROR, ERR_UNKNOWN, line_count);
              mode_next = M_ERROR;
            end
          end
        endcase
      end

      if (nl) begin
        tp = push(tp, K_EOL, '0, line_count);
        if (line_count != {LINE_BITS{1'b1}}) line_next = line_count + LINE_BITS'(1);
      end
    end

    if (tp.cnt == 2'd1) tp.t0.last = 1'b1;
    if (tp.cnt == 2'd2) tp.t1.last = 1'b1;
    toks = tp;
  end

  `QCT_ASSERT_IMP(a_line_nonzero, 1'b1, line_count != '0)
  `QCT_ASSERT_IMP(a_error_quiet, mode == M_ERROR && !eoi, toks.cnt == 2'd0)
  `QCT_ASSERT_NXT(a_eof_resets, step && eoi, mode == M_IDLE && line_count == LINE_BITS'(1))

endmodule

>>> hdl/qcir_char_tokenizer.sv
// The tokens of an item are registered into the output queue when the item is taken.
// One character per cycle while s_tready is high; each token is its own output transfer.
// s_tready falls while the four-entry output queue has fewer than two free slots.
// Reset (rst, synchronous): scanner idle, line count one, output queue empty.
// An end-of-input item also returns the scanner to its reset state.
`include "qcir_char_tokenizer_assert.svh"

module qcir_char_tokenizer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [qct_pkg::CHAR_W-1:0]     s_tdata,   // [7:0] char_code
  input  logic                           s_tlast,   // end_of_input
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [qct_pkg::OUT_DATA_W-1:0] m_tdata,   // token_kind, token_value, line_number
  output logic                           m_tlast    // last
);
  import qct_pkg::*;

  logic                  accept;
  logic                  pop;
  tok_pair_t             toks;
  tok_t                  q [OUTQ_DEPTH];
  tok_t                  head;
  logic [OUTQ_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [OUTQ_CNT_W-1:0] count, count_next;
  logic [OUTQ_CNT_W-1:0] push_n;

  qct_lexer u_lexer (
    .clk  (clk),
    .rst  (rst),
    .step (accept),
    .ch   (s_tdata),
    .eoi  (s_tlast),
    .toks (toks)
  );

  assign s_tready = count <= OUTQ_CNT_W'(OUTQ_DEPTH - 2);
  assign accept = s_tvalid && s_tready;
  assign m_tvalid = count != '0;
  assign pop = m_tvalid && m_tready;
  assign push_n = accept ? OUTQ_CNT_W'(toks.cnt) : '0;
  assign count_next = count + push_n - OUTQ_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wr_ptr + OUTQ_PTR_W'(push_n);
      rd_ptr <= rd_ptr + OUTQ_PTR_W'(pop);
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && toks.cnt != 2'd0) q[wr_ptr] <= toks.t0;
    if (accept && toks.cnt == 2'd2) q[wr_ptr + OUTQ_PTR_W'(1)] <= toks.t1;
  end

  assign head = q[rd_ptr];
  assign m_tdata = {{(OUT_DATA_W - TOKEN_W){1'b0}}, head.line, head.value, head.kind};
  assign m_tlast = head.last;

  `QCT_ASSERT_IMP(a_queue_bound, 1'b1, count <= OUTQ_CNT_W'(OUTQ_DEPTH))
  `QCT_ASSERT_NXT(a_eof_queued, accept && s_tlast, count != '0)
  `QCT_ASSERT_NXT(a_drain_step, pop && !accept, count == $past(count) - OUTQ_CNT_W'(1))

endmodule
